/* design/olar_pkg.sv */
// ----------------------------------------------------------------------------
// olar_pkg
// Shared types, constants and helpers of the override lock with auto release.
// ----------------------------------------------------------------------------
package olar_pkg;

	localparam int unsigned MS_W     = 32;
	localparam int unsigned DAY_W    = 9;
	localparam int unsigned MINUTE_W = 11;
	localparam int unsigned POLICY_W = 3;
	localparam int unsigned MODE_W   = 4;
	localparam int unsigned RMIN_W   = 16;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [MS_W-1:0] MS_PER_MIN  = MS_W'(1 * 60 * 1000);
	localparam logic [MS_W-1:0] MS_PER_HOUR = MS_W'(60 * 60 * 1000);
	localparam logic [RMIN_W-1:0] NO_MINUTE = 16'hFFFF;

	localparam logic [MODE_W-1:0] MODE_NONE     = 4'd0;
	localparam logic [MODE_W-1:0] MODE_NEXT_DAY = 4'd12;

	localparam logic KIND_LOCK = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef enum logic [POLICY_W-1:0] {
		POL_LEGACY      = 3'd0,
		POL_DURATION    = 3'd1,
		POL_TIME        = 3'd2,
		POL_DUR_OR_TIME = 3'd3,
		POL_EXTERNAL    = 3'd4,
		POL_DISABLED    = 3'd5
	} olar_policy_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RELEASE_POLICY = 2'd0,
		CFG_LEGACY_MODE    = 2'd1,
		CFG_HOLD_DURATION  = 2'd2,
		CFG_RELEASE_MINUTE = 2'd3
	} olar_cfg_idx_t;

	typedef struct packed {
		logic [POLICY_W-1:0] release_policy;
		logic [MODE_W-1:0]   legacy_mode;
		logic [MS_W-1:0]     hold_duration_ms;
		logic [RMIN_W-1:0]   release_minute;
	} olar_cfg_t;

	typedef struct packed {
		logic                kind;
		logic                lock_request;
		logic [MS_W-1:0]     now_ms;
		logic                time_valid;
		logic [DAY_W-1:0]    day_of_year;
		logic [MINUTE_W-1:0] minute_of_day;
	} olar_item_t;

	typedef struct packed {
		logic                locked;
		logic [MS_W-1:0]     release_deadline;
		logic                stamp_valid;
		logic [DAY_W-1:0]    activation_day;
		logic [MINUTE_W-1:0] activation_minute;
	} olar_state_t;

	localparam olar_state_t STATE_CLEAR = '0;

	function automatic olar_policy_t eff_policy(input logic [POLICY_W-1:0] raw);
		olar_policy_t pol;
		if (raw > POLICY_W'(POL_DISABLED))
			pol = POL_LEGACY;
		else
			pol = olar_policy_t'(raw);
		return pol;
	endfunction

	function automatic logic [MS_W-1:0] legacy_duration(input logic [MODE_W-1:0] mode);
		logic [MS_W-1:0] d;
		case (mode)
			4'd1:    d = MS_W'(1 * MS_PER_MIN);
			4'd2:    d = MS_W'(2 * MS_PER_MIN);
			4'd3:    d = MS_W'(5 * MS_PER_MIN);
			4'd4:    d = MS_W'(10 * MS_PER_MIN);
			4'd5:    d = MS_W'(20 * MS_PER_MIN);
			4'd6:    d = MS_W'(30 * MS_PER_MIN);
			4'd7:    d = MS_W'(1 * MS_PER_HOUR);
			4'd8:    d = MS_W'(2 * MS_PER_HOUR);
			4'd9:    d = MS_W'(5 * MS_PER_HOUR);
			4'd10:   d = MS_W'(8 * MS_PER_HOUR);
			4'd11:   d = MS_W'(12 * MS_PER_HOUR);
			default: d = '0;
		endcase
		return d;
	endfunction

endpackage

/* design/olar_if.sv */
// ----------------------------------------------------------------------------
// olar channel interfaces
// Command, result and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
interface olar_cmd_if;
	import olar_pkg::*;
	logic                valid;
	logic                ready;
	logic                kind;
	logic                lock_request;
	logic [MS_W-1:0]     now_ms;
	logic                time_valid;
	logic [DAY_W-1:0]    day_of_year;
	logic [MINUTE_W-1:0] minute_of_day;

	modport source (output valid, kind, lock_request, now_ms, time_valid, day_of_year,
		minute_of_day, input ready);
	modport sink (input valid, kind, lock_request, now_ms, time_valid, day_of_year,
		minute_of_day, output ready);
endinterface

interface olar_res_if;
	logic valid;
	logic ready;
	logic lock_active;
	logic status_publish;

	modport source (output valid, lock_active, status_publish, input ready);
	modport sink (input valid, lock_active, status_publish, output ready);
endinterface

interface olar_cfg_if;
	import olar_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  addr;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

/* design/olar_eval.sv */
// ----------------------------------------------------------------------------
// olar_eval
// Next-state and publish evaluation for one command or tick transaction.
// ----------------------------------------------------------------------------
module olar_eval (
	input  olar_pkg::olar_cfg_t   cfg_i,
	input  olar_pkg::olar_item_t  item,
	input  olar_pkg::olar_state_t cur,
	output olar_pkg::olar_state_t nxt,
	output logic                  publish
);
	import olar_pkg::*;

	olar_policy_t       pol;
	logic [MS_W-1:0]    dur;
	logic [MS_W-1:0]    arm_deadline;
	logic [MS_W-1:0]    elapsed;
	logic               passed;
	logic [RMIN_W-1:0]  act_min_x;
	logic [RMIN_W-1:0]  min_x;
	logic               by_time;
	logic               next_day;
	olar_state_t        armed;

	assign pol = eff_policy(cfg_i.release_policy);

	always_comb begin
		case (pol)
			POL_LEGACY:                    dur = legacy_duration(cfg_i.legacy_mode);
			POL_DURATION, POL_DUR_OR_TIME: dur = cfg_i.hold_duration_ms;
			default:                       dur = '0;
		endcase
	end

	assign arm_deadline = (dur != '0) ? item.now_ms + dur : '0;

	assign elapsed = item.now_ms - cur.release_deadline;
	assign passed  = (cur.release_deadline != '0) && !elapsed[MS_W-1];

	assign act_min_x = RMIN_W'(cur.activation_minute);
	assign min_x     = RMIN_W'(item.minute_of_day);

	assign by_time = (pol == POL_TIME || pol == POL_DUR_OR_TIME) && item.time_valid
		&& (cfg_i.release_minute != NO_MINUTE) && cur.stamp_valid
		&& !(item.day_of_year < cur.activation_day)
		&& !(item.day_of_year == cur.activation_day && cfg_i.release_minute <= act_min_x)
		&& (min_x >= cfg_i.release_minute);

	assign next_day = (cfg_i.legacy_mode == MODE_NEXT_DAY) && item.time_valid
		&& cur.stamp_valid && (item.day_of_year != cur.activation_day);

	always_comb begin
		armed                   = STATE_CLEAR;
		armed.locked            = 1'b1;
		armed.release_deadline  = arm_deadline;
		if (item.time_valid) begin
			armed.stamp_valid       = 1'b1;
			armed.activation_day    = item.day_of_year;
			armed.activation_minute = item.minute_of_day;
		end
	end

	always_comb begin
		nxt     = cur;
		publish = 1'b0;
		if (item.kind == KIND_LOCK) begin
			if (item.lock_request && pol == POL_DISABLED) begin
				nxt = cur;
			end else if (item.lock_request) begin
				nxt     = armed;
				publish = 1'b1;
			end else begin
				nxt     = STATE_CLEAR;
				publish = 1'b1;
			end
		end else if (cur.locked && pol != POL_EXTERNAL) begin
			if (pol != POL_LEGACY) begin
				if (passed || by_time) begin
					nxt     = STATE_CLEAR;
					publish = 1'b1;
				end
			end else if (cfg_i.legacy_mode != MODE_NONE) begin
				if (cur.release_deadline != '0) begin
					if (passed) begin
						nxt     = STATE_CLEAR;
						publish = 1'b1;
					end
				end else if (next_day) begin
					nxt     = STATE_CLEAR;
					publish = 1'b1;
				end
			end
		end
	end

endmodule

/* design/override_lock_auto_release_core.sv */
// ----------------------------------------------------------------------------
// override_lock_auto_release_core
// Override lock with automatic release by deadline, minute of day or day change.
// ----------------------------------------------------------------------------
// channel | dir | payload
// cmd     | in  | kind, lock_request, now_ms, time_valid, day_of_year, minute_of_day
// res     | out | lock_active, status_publish
// cfg     | in  | addr (register index), data
//
// One transaction per cycle sustained while res is ready; cmd reaches res through
// the input register, then evaluation into the result register.
// Lock state is updated as a transaction leaves the input register.
// res stalls back-pressure cmd only when both registers are full.
// cfg is always ready; arst_n clears lock state and resets configuration to defaults.
// ----------------------------------------------------------------------------
module override_lock_auto_release_core (
	input logic        clk,
	input logic        arst_n,
	olar_cmd_if.sink   cmd,
	olar_res_if.source res,
	olar_cfg_if.sink   cfg
);
	import olar_pkg::*;

	olar_cfg_t   cfg_q;
	olar_state_t st_q;
	olar_state_t st_next;
	olar_item_t  item_s1;
	logic        valid_s1;
	logic        out_valid_q;
	logic        lock_q;
	logic        publish_q;
	logic        ev_publish;
	logic        adv;
	logic        out_free;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.release_policy   <= POLICY_W'(POL_LEGACY);
			cfg_q.legacy_mode      <= MODE_NONE;
			cfg_q.hold_duration_ms <= '0;
			cfg_q.release_minute   <= NO_MINUTE;
		end else if (cfg.valid) begin
			case (olar_cfg_idx_t'(cfg.addr))
				CFG_RELEASE_POLICY: cfg_q.release_policy   <= cfg.data[POLICY_W-1:0];
				CFG_LEGACY_MODE:    cfg_q.legacy_mode      <= cfg.data[MODE_W-1:0];
				CFG_HOLD_DURATION:  cfg_q.hold_duration_ms <= cfg.data[MS_W-1:0];
				CFG_RELEASE_MINUTE: cfg_q.release_minute   <= cfg.data[RMIN_W-1:0];
				default:            cfg_q <= cfg_q;
			endcase
		end
	end

	assign out_free  = !out_valid_q || res.ready;
	assign adv       = valid_s1 && out_free;
	assign cmd.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1.kind          <= cmd.kind;
			item_s1.lock_request  <= cmd.lock_request;
			item_s1.now_ms        <= cmd.now_ms;
			item_s1.time_valid    <= cmd.time_valid;
			item_s1.day_of_year   <= cmd.day_of_year;
			item_s1.minute_of_day <= cmd.minute_of_day;
		end
	end

	olar_eval u_eval (
		.cfg_i   (cfg_q),
		.item    (item_s1),
		.cur     (st_q),
		.nxt     (st_next),
		.publish (ev_publish)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_CLEAR;
		end else if (adv) begin
			st_q <= st_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lock_q    <= st_next.locked;
			publish_q <= ev_publish;
		end
	end

	assign res.valid          = out_valid_q;
	assign res.lock_active    = lock_q;
	assign res.status_publish = publish_q;

	a_deadline_locked: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.release_deadline != '0) |-> st_q.locked)
		else $error("release deadline armed while unlocked");

	a_stamp_locked: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.stamp_valid |-> st_q.locked)
		else $error("activation stamp valid while unlocked");

	a_quiet_keeps_lock: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !ev_publish) |=> (st_q.locked == $past(st_q.locked)))
		else $error("lock state changed without publish");

	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("transaction lost between input and result registers");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(item_s1)))
		else $error("stalled transaction dropped from input register");

endmodule
